// ===== rtl/core/tdpc_pkg.sv =====
// Shared types and constants for the timed dispense pump controller.
`default_nettype none

package tdpc_pkg;

    // Channel count and the number of pumps actually in service
    localparam int CHANNELS   = 3;
    localparam int PUMP_COUNT = 3;

    // Field widths
    localparam int REQ_W     = 3;
    localparam int ID_W      = 8;
    localparam int VOL_W     = 8;
    localparam int CAL_W     = 10;
    localparam int TIME_W    = 18;
    localparam int ERR_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Calibration after reset, tenths of a second per 100 ml
    localparam logic [CAL_W-1:0] CAL_RESET [CHANNELS] = '{10'd30, 10'd80, 10'd120};

    // Request codes; the unused codes act as a status query
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK     = 3'd0,
        REQ_START    = 3'd1,
        REQ_STOP     = 3'd2,
        REQ_STOP_ALL = 3'd3,
        REQ_STATUS   = 3'd4
    } req_e;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_INVALID = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BUSY    = 2'd2;

    // Input item
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [ID_W-1:0]  pump_id;
        logic [VOL_W-1:0] dose_ml;
    } req_item_t;

    // Result item
    typedef struct packed {
        logic                accepted;
        logic [CHANNELS-1:0] running_mask;
        logic                system_running;
        logic [ERR_W-1:0]    err_code;
    } rsp_item_t;

    // Command from the request decoder to one channel
    typedef struct packed {
        logic tick;
        logic load;
        logic clear;
    } chan_cmd_t;

    // Status from one channel back to the decoder
    typedef struct packed {
        logic on;
        logic on_next;
        logic dur_zero;
    } chan_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tdpc_channel.sv =====
// One pump channel: drive flag, millisecond countdown and dispense time product.
`default_nettype none

module tdpc_channel
    import tdpc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CAL_W-1:0] cal,
    input  wire logic [VOL_W-1:0] dose_ml,
    input  wire chan_cmd_t        cmd,
    output chan_stat_t            stat
);

    logic              on_reg;
    logic              on_next;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    logic [TIME_W-1:0] dur;

    // Dispense time in ms: tenths of s per 100 ml times ml
    assign dur = TIME_W'(cal) * TIME_W'(dose_ml);

    // Apply load, clear or one tick of countdown
    always_comb
    begin
        on_next   = on_reg;
        time_next = time_reg;
        if (cmd.clear)
        begin
            on_next   = 1'b0;
            time_next = '0;
        end
        else if (cmd.load)
        begin
            on_next   = 1'b1;
            time_next = dur;
        end
        else if (cmd.tick && on_reg)
        begin
            if (time_reg <= TIME_W'(1))
            begin
                on_next   = 1'b0;
                time_next = '0;
            end
            else
            begin
                time_next = time_reg - TIME_W'(1);
            end
        end
    end

    // Hold channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg   <= 1'b0;
            time_reg <= '0;
        end
        else
        begin
            on_reg   <= on_next;
            time_reg <= time_next;
        end
    end

    assign stat.on       = on_reg;
    assign stat.on_next  = on_next;
    assign stat.dur_zero = (dur == '0);

endmodule

`default_nettype wire

// ===== rtl/core/timed_dispense_pump_controller_top.sv =====
// Top level of the timed dispense pump controller: request stage, decode, result stage.
`default_nettype none

// Takes one item per clock while req_stall is low and returns one result item per
// item. An accepted item lands in the input register, is decoded and applied to
// the three channel countdowns in one pass, and its result lands in the output
// register when that stage is free or draining, which raises rsp_valid. A
// stalled result holds the output register and then the input register;
// req_stall rises only when both are full. Each tick item counts every running
// channel down by one ms. The user must write calibration through the cfg port
// only while no item is in flight; the block does not enforce it. Index 3 is ignored.
module timed_dispense_pump_controller_top
    import tdpc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CAL_W-1:0]     cfg_data,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire req_item_t            req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output rsp_item_t                 rsp
);

    logic [CAL_W-1:0] cal_reg [CHANNELS];

    logic       s1_valid_reg;
    req_item_t  s1_item_reg;
    logic       s1_move;

    logic       rsp_valid_reg;
    rsp_item_t  rsp_reg;
    rsp_item_t  rsp_next;

    logic             sys_flag_reg;
    logic             sys_flag_next;
    logic [ERR_W-1:0] err_reg;
    logic [ERR_W-1:0] err_next;

    chan_cmd_t           cmd    [CHANNELS];
    chan_stat_t          stat   [CHANNELS];
    logic [CHANNELS-1:0] hit;
    logic                id_ok;
    logic                sel_on;
    logic                sel_zero;
    logic                accept_start;
    logic [CHANNELS-1:0] on_now;
    logic [CHANNELS-1:0] on_after;

    // Write calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                cal_reg[i] <= CAL_RESET[i];
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
                if (cfg_wr_en && cfg_index == CFG_IDX_W'(i))
                    cal_reg[i] <= cfg_data;
        end
    end

    // Advance the request stage when the result stage is free or draining
    assign s1_move   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!req_stall)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
            s1_item_reg <= req;
    end

    // Select the addressed channel
    always_comb
    begin
        id_ok    = (s1_item_reg.pump_id >= ID_W'(1)) &&
                   (s1_item_reg.pump_id <= ID_W'(PUMP_COUNT));
        sel_on   = 1'b0;
        sel_zero = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            hit[i]    = id_ok && (s1_item_reg.pump_id == ID_W'(i + 1));
            on_now[i] = stat[i].on;
            if (hit[i])
            begin
                sel_on   = stat[i].on;
                sel_zero = stat[i].dur_zero;
            end
        end
    end

    // Decode the request into channel commands and new flag and error
    always_comb
    begin
        accept_start  = 1'b0;
        sys_flag_next = sys_flag_reg;
        err_next      = err_reg;
        for (int i = 0; i < CHANNELS; i++)
            cmd[i] = '0;

        if (s1_move)
        begin
            unique case (s1_item_reg.req_type)
                REQ_TICK:
                begin
                    sys_flag_next = |on_now;
                    for (int i = 0; i < CHANNELS; i++)
                        cmd[i].tick = 1'b1;
                end
                REQ_START:
                begin
                    if (!id_ok)
                        err_next = ERR_INVALID;
                    else if (sel_on)
                        err_next = ERR_BUSY;
                    else if (sel_zero)
                        err_next = ERR_INVALID;
                    else
                    begin
                        err_next     = ERR_OK;
                        accept_start = 1'b1;
                        for (int i = 0; i < CHANNELS; i++)
                            cmd[i].load = hit[i];
                    end
                end
                REQ_STOP:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                        cmd[i].clear = hit[i];
                end
                REQ_STOP_ALL:
                begin
                    err_next = ERR_OK;
                    for (int i = 0; i < CHANNELS; i++)
                        cmd[i].clear = 1'b1;
                end
                default:
                begin
                    err_next = err_reg;
                end
            endcase
        end
    end

    // Channel countdowns
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_chan
        tdpc_channel u_chan (
            .clk     (clk),
            .rst_n   (rst_n),
            .cal     (cal_reg[g]),
            .dose_ml (s1_item_reg.dose_ml),
            .cmd     (cmd[g]),
            .stat    (stat[g])
        );
    end

    // Build the result from the state after the item acts
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
            on_after[i] = stat[i].on_next;
        rsp_next.accepted       = accept_start;
        rsp_next.running_mask   = on_after;
        rsp_next.system_running = sys_flag_next;
        rsp_next.err_code       = err_next;
    end

    // Hold flag, error and the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_flag_reg  <= 1'b0;
            err_reg       <= ERR_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            sys_flag_reg <= sys_flag_next;
            err_reg      <= err_next;
            if (s1_move)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted start reports no error and a running pump
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.accepted) |-> (rsp.err_code == ERR_OK && rsp.running_mask != '0))
        else $error("accepted start with error or no pump running");

    // Error state moves only when an item passes through
    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(err_reg))
        else $error("error state changed without an item");

    // The error code never takes the unused value
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.err_code == ERR_OK || rsp.err_code == ERR_INVALID ||
                       rsp.err_code == ERR_BUSY))
        else $error("error code out of range");

    // A stalled result is not overwritten by a new item
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |-> !s1_move)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ===== sim/tb_timed_dispense_pump_controller_top.sv =====
// Testbench for the timed dispense pump controller: directed and random items, checked per result.
module tb_timed_dispense_pump_controller_top;
    import tdpc_pkg::*;

    // Request codes with no name in the package; the block treats them as a status query
    localparam logic [REQ_W-1:0] REQ_UNDEF_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNDEF_LAST  = 3'd7;

    // Calibration register indexes; the last one has no register behind it
    localparam logic [CFG_IDX_W-1:0] CAL_IDX_PUMP1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CAL_IDX_PUMP2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CAL_IDX_PUMP3 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CAL_IDX_SPARE = 2'd3;

    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TICKS = 6;
    localparam int REPORT_MAX   = 10;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_BURST} stall_mode_e;

    // Tracks the controller state and holds the status items still to come back
    class dispense_checker;
        logic [CAL_W-1:0]  cal_tenths [CHANNELS];
        bit                drive_on   [CHANNELS];
        logic [TIME_W-1:0] ms_left    [CHANNELS];
        bit                sys_running;
        logic [ERR_W-1:0]  last_err;
        rsp_item_t         expected_status_q [$];
        int                mismatches;

        function new();
            for (int i = 0; i < CHANNELS; i++)
            begin
                cal_tenths[i] = CAL_RESET[i];
                drive_on[i]   = 1'b0;
                ms_left[i]    = '0;
            end
            sys_running = 1'b0;
            last_err    = ERR_OK;
            mismatches  = 0;
        endfunction

        function void set_cal(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] value);
            if (idx < CHANNELS)
                cal_tenths[idx] = value;
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction

        // Apply one accepted request and queue the status it must produce
        function void predict_status(req_item_t it);
            rsp_item_t                 st;
            int                        idx;
            bit                        any;
            bit                        acc;
            logic [CAL_W+VOL_W-1:0]    prod;
            acc = 1'b0;
            case (it.req_type)
                REQ_TICK:
                begin
                    any = 1'b0;
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (drive_on[i])
                        begin
                            any = 1'b1;
                            if (ms_left[i] <= 1)
                            begin
                                ms_left[i]  = '0;
                                drive_on[i] = 1'b0;
                            end
                            else
                                ms_left[i] = ms_left[i] - 1'b1;
                        end
                    end
                    sys_running = any;
                end
                REQ_START:
                begin
                    if (it.pump_id == 0 || it.pump_id > PUMP_COUNT)
                        last_err = ERR_INVALID;
                    else
                    begin
                        idx = it.pump_id - 1;
                        prod = cal_tenths[idx] * it.dose_ml;
                        if (drive_on[idx])
                            last_err = ERR_BUSY;
                        else if (prod[TIME_W-1:0] == 0)
                            last_err = ERR_INVALID;
                        else
                        begin
                            drive_on[idx] = 1'b1;
                            ms_left[idx]  = prod[TIME_W-1:0];
                            last_err      = ERR_OK;
                            acc           = 1'b1;
                        end
                    end
                end
                REQ_STOP:
                begin
                    if (it.pump_id >= 1 && it.pump_id <= PUMP_COUNT)
                    begin
                        drive_on[it.pump_id - 1] = 1'b0;
                        ms_left[it.pump_id - 1]  = '0;
                    end
                end
                REQ_STOP_ALL:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        drive_on[i] = 1'b0;
                        ms_left[i]  = '0;
                    end
                    last_err = ERR_OK;
                end
                default: ;
            endcase
            st.accepted = acc;
            for (int i = 0; i < CHANNELS; i++)
                st.running_mask[i] = drive_on[i];
            st.system_running = sys_running;
            st.err_code       = last_err;
            expected_status_q.push_back(st);
        endfunction

        // Compare one returned status with the oldest expected one
        function void check_status(rsp_item_t got);
            rsp_item_t want;
            bit        bad;
            if (expected_status_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("status item with none expected: acc=%0d mask=%b run=%0d err=%0d",
                             got.accepted, got.running_mask, got.system_running,
                             got.err_code);
                return;
            end
            want = expected_status_q.pop_front();
            bad = 1'b0;
            if (got.accepted !== want.accepted)             bad = 1'b1;
            if (got.running_mask !== want.running_mask)     bad = 1'b1;
            if (got.system_running !== want.system_running) bad = 1'b1;
            if (got.err_code !== want.err_code)             bad = 1'b1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("status mismatch: expected acc=%0d mask=%b run=%0d err=%0d,",
                             want.accepted, want.running_mask, want.system_running,
                             want.err_code,
                             " got acc=%0d mask=%b run=%0d err=%0d",
                             got.accepted, got.running_mask,
                             got.system_running, got.err_code);
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CAL_W-1:0]     cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_item_t            req_item  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_item_t            rsp_item;

    dispense_checker board = new();

    stall_mode_e stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    timed_dispense_pump_controller_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Note accepted requests, check accepted status items, and guard against a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                board.predict_status(req_item);
            if (rsp_valid && !rsp_stall)
                board.check_status(rsp_item);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Stall the status side in changing patterns, with calm stretches in between
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: rsp_stall <= (mode_left % 3 == 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_stall <= 1'b1;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(1, 12);
                    rsp_stall <= 1'b1;
                end
                else
                    rsp_stall <= 1'b0;
            end
        endcase
    end

    // Present one request and hold it until taken
    task automatic send_request(input req_item_t it);
        req_valid <= 1'b1;
        req_item  <= it;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic send_fields(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                               input logic [VOL_W-1:0] vol);
        req_item_t it;
        it.req_type = kind;
        it.pump_id  = id;
        it.dose_ml  = vol;
        send_request(it);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected status has come back
    task automatic wait_for_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.set_cal(idx, value);
    endtask

    // Load all three calibrations, optionally poking the unused index as well
    task automatic apply_cal(input logic [CAL_W-1:0] c1, input logic [CAL_W-1:0] c2,
                             input logic [CAL_W-1:0] c3, input bit poke_spare);
        write_cal(CAL_IDX_PUMP1, c1);
        write_cal(CAL_IDX_PUMP2, c2);
        write_cal(CAL_IDX_PUMP3, c3);
        if (poke_spare)
            write_cal(CAL_IDX_SPARE, CAL_W'($urandom_range(0, 1023)));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly ticks and starts on real pumps with short volumes, plus stops and noise
    function automatic req_item_t make_request();
        req_item_t it;
        int        pick;
        int        vpick;
        pick        = $urandom_range(0, 99);
        vpick       = $urandom_range(0, 9);
        it.pump_id  = ID_W'($urandom_range(0, 255));
        it.dose_ml  = VOL_W'($urandom_range(0, 255));
        if (pick < 45)
            it.req_type = REQ_TICK;
        else if (pick < 72)
        begin
            it.req_type = REQ_START;
            if ($urandom_range(0, 9) < 8)
                it.pump_id = ID_W'($urandom_range(1, PUMP_COUNT));
            if (vpick < 7)
                it.dose_ml = VOL_W'($urandom_range(1, 12));
            else if (vpick == 9)
                it.dose_ml = '0;
        end
        else if (pick < 82)
        begin
            it.req_type = REQ_STOP;
            if ($urandom_range(0, 9) < 8)
                it.pump_id = ID_W'($urandom_range(1, PUMP_COUNT));
        end
        else if (pick < 86)
            it.req_type = REQ_STOP_ALL;
        else if (pick < 94)
            it.req_type = REQ_STATUS;
        else
            it.req_type = REQ_W'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST));
        return it;
    endfunction

    // Random items in bursts; drain once at pause_at when it is in range
    task automatic run_random(input int count, input int pause_at);
        int burst_left;
        burst_left = 0;
        for (int k = 0; k < count; k++)
        begin
            if (k == pause_at)
                wait_for_results();
            if (burst_left == 0)
            begin
                hold_off(($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(0, 4));
                burst_left = $urandom_range(1, 40);
            end
            send_request(make_request());
            burst_left--;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: error paths, busy, bad ids, stop cases, unknown codes, stop-all
        send_fields(REQ_STATUS,   8'd0,   8'd0);
        send_fields(REQ_TICK,     8'hFF,  8'hFF);
        send_fields(REQ_START,    8'd1,   8'd255);
        send_fields(REQ_START,    8'd1,   8'd1);
        send_fields(REQ_START,    8'd0,   8'd10);
        send_fields(REQ_START,    8'd4,   8'd10);
        send_fields(REQ_START,    8'd255, 8'd255);
        send_fields(REQ_START,    8'd2,   8'd0);
        send_fields(REQ_START,    8'd3,   8'd1);
        send_fields(REQ_TICK,     8'd0,   8'd0);
        send_fields(REQ_STOP,     8'd0,   8'd0);
        send_fields(REQ_STOP,     8'd200, 8'd0);
        send_fields(REQ_STOP,     8'd1,   8'd0);
        send_fields(REQ_TICK,     8'd0,   8'd0);
        send_fields(REQ_UNDEF_FIRST,             8'd1, 8'd5);
        send_fields(REQ_W'(REQ_UNDEF_FIRST + 1), 8'd2, 8'd6);
        send_fields(REQ_UNDEF_LAST,              8'd3, 8'd7);
        send_fields(REQ_START,    8'd0,   8'd1);
        send_fields(REQ_STOP_ALL, 8'd0,   8'd0);
        send_fields(REQ_TICK,     8'd0,   8'd0);
        wait_for_results();

        // Shortest dispense: one ms runs out on the next tick, then standby
        apply_cal(10'd1, 10'd1, 10'd1, 1'b0);
        send_fields(REQ_START, 8'd1, 8'd1);
        send_fields(REQ_START, 8'd3, 8'd255);
        send_fields(REQ_TICK,  8'd0, 8'd0);
        send_fields(REQ_STOP,  8'd3, 8'd0);
        send_fields(REQ_TICK,  8'd0, 8'd0);
        run_random(300, -1);
        wait_for_results();

        // Zero calibration and the largest product
        apply_cal(10'd0, 10'd1023, 10'd1, 1'b1);
        send_fields(REQ_START, 8'd1, 8'd255);
        send_fields(REQ_START, 8'd2, 8'd255);
        run_random(300, -1);
        wait_for_results();

        apply_cal(10'd3, 10'd7, 10'd2, 1'b0);
        run_random(300, 150);
        wait_for_results();

        apply_cal(10'd600, 10'd5, 10'd1, 1'b0);
        run_random(250, -1);
        wait_for_results();

        apply_cal(CAL_W'($urandom_range(1, 8)), CAL_W'($urandom_range(1, 8)),
                  CAL_W'($urandom_range(1, 8)), 1'b1);
        run_random(300, -1);
        wait_for_results();

        apply_cal(10'd1023, 10'd1023, 10'd1023, 1'b0);
        run_random(200, -1);
        wait_for_results();

        apply_cal(10'd2, 10'd1, 10'd4, 1'b1);
        run_random(300, -1);
        wait_for_results();

        if (board.mismatches == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tdpc_pkg.sv
rtl/core/tdpc_channel.sv
rtl/core/timed_dispense_pump_controller_top.sv
sim/tb_timed_dispense_pump_controller_top.sv
